// File: sv/scer_pkg.sv
`timescale 1ns / 1ps
// Package for the signal change event recorder: sizes, field offsets, types, helpers.
package scer_pkg;

  // Ring geometry
  localparam int unsigned DEPTH  = 512;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned AGE_W  = 9;
  localparam int unsigned CALC_W = ((CNT_W > AGE_W) ? CNT_W : AGE_W) + 2;

  // Entry fields
  localparam int unsigned WORDS   = 9;
  localparam int unsigned SIG_W   = 32 * WORDS;
  localparam int unsigned SEC_W   = 63;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned ENTRY_W = SIG_W + SEC_W + MS_W;
  localparam int unsigned PC_W    = 6;
  localparam int unsigned CHG_W   = 9;
  localparam int unsigned STORED_W = 10;

  localparam logic [SEC_W-1:0] MIN_TIME_RESET = SEC_W'(64'd1203161493);

  // Input tdata layout
  localparam int unsigned IN_TDATA_W = 376;
  localparam int unsigned IN_SIG_LSB = 0;
  localparam int unsigned IN_SEC_LSB = IN_SIG_LSB + SIG_W;
  localparam int unsigned IN_MS_LSB  = IN_SEC_LSB + SEC_W;
  localparam int unsigned IN_AGE_LSB = IN_MS_LSB + MS_W;

  // Output tdata layout
  localparam int unsigned OUT_TDATA_W = 384;
  localparam int unsigned O_REC       = 0;
  localparam int unsigned O_CNT_LSB   = 1;
  localparam int unsigned O_VALID     = O_CNT_LSB + STORED_W;
  localparam int unsigned O_SIG_LSB   = O_VALID + 1;
  localparam int unsigned O_SEC_LSB   = O_SIG_LSB + SIG_W;
  localparam int unsigned O_MS_LSB    = O_SEC_LSB + SEC_W;
  localparam int unsigned O_CHG_LSB   = O_MS_LSB + MS_W;

  // Command codes carried on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_RD_NEW,
    ST_RD_OLD,
    ST_RD_CNT,
    ST_RD_OUT
  } scer_state_e;

  // Controller to datapath
  typedef struct packed {
    logic in_load;
    logic sample_go;
    logic rd_en;
    logic rd_older;
    logic ent_load;
    logic pc_load;
    logic read_go;
  } scer_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } scer_sts_t;

  // SWAR population count of one 32-bit word
  function automatic logic [PC_W-1:0] popcount32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[PC_W-1:0];
  endfunction

endpackage

// File: sv/scer_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the signal change event recorder.
module scer_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  cmd_read_i,
  output logic                  s_axis_tready,
  input  scer_pkg::scer_sts_t   sts_i,
  output scer_pkg::scer_cmd_t   cmd_o
);

  scer_pkg::scer_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scer_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scer_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (cmd_read_i == scer_pkg::CMD_READ) ? scer_pkg::ST_RD_NEW
                                                       : scer_pkg::ST_SAMPLE;
        end
      end
      scer_pkg::ST_SAMPLE: begin
        if (sts_i.out_free) state_d = scer_pkg::ST_IDLE;
      end
      scer_pkg::ST_RD_NEW: state_d = scer_pkg::ST_RD_OLD;
      scer_pkg::ST_RD_OLD: state_d = scer_pkg::ST_RD_CNT;
      scer_pkg::ST_RD_CNT: state_d = scer_pkg::ST_RD_OUT;
      scer_pkg::ST_RD_OUT: begin
        if (sts_i.out_free) state_d = scer_pkg::ST_IDLE;
      end
      default: state_d = scer_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      scer_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.in_load = s_axis_tvalid;
      end
      scer_pkg::ST_SAMPLE: cmd_o.sample_go = sts_i.out_free;
      scer_pkg::ST_RD_NEW: cmd_o.rd_en = 1'b1;
      scer_pkg::ST_RD_OLD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_older = 1'b1;
        cmd_o.ent_load = 1'b1;
      end
      scer_pkg::ST_RD_CNT: cmd_o.pc_load = 1'b1;
      scer_pkg::ST_RD_OUT: cmd_o.read_go = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: sv/scer_datapath.sv
`timescale 1ns / 1ps
// Datapath of the signal change event recorder: ring memory, pointers, popcount, result register.
module scer_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  scer_pkg::scer_cmd_t                  cmd_i,
  output scer_pkg::scer_sts_t                  sts_o,
  input  logic [scer_pkg::IN_TDATA_W-1:0]      in_tdata_i,
  input  logic                                 cfg_we_i,
  input  logic [scer_pkg::SEC_W-1:0]           cfg_wdata_i,
  output logic                                 out_tvalid_o,
  input  logic                                 out_tready_i,
  output logic [scer_pkg::OUT_TDATA_W-1:0]     out_tdata_o
);

  localparam int unsigned PTR_W  = scer_pkg::PTR_W;
  localparam int unsigned CNT_W  = scer_pkg::CNT_W;
  localparam int unsigned CALC_W = scer_pkg::CALC_W;
  localparam int unsigned SIG_W  = scer_pkg::SIG_W;
  localparam int unsigned SEC_W  = scer_pkg::SEC_W;
  localparam int unsigned MS_W   = scer_pkg::MS_W;
  localparam int unsigned WORDS  = scer_pkg::WORDS;

  // Captured input item
  logic [SIG_W-1:0]           in_sig_q;
  logic [SEC_W-1:0]           in_sec_q;
  logic [MS_W-1:0]            in_ms_q;
  logic [scer_pkg::AGE_W-1:0] in_age_q;

  // Recorder state
  logic [SEC_W-1:0] min_time_q;
  logic [SIG_W-1:0] last_q;
  logic [PTR_W-1:0] wp_q;
  logic [CNT_W-1:0] cnt_q;

  // Ring and read path
  logic [scer_pkg::ENTRY_W-1:0] ring_mem [scer_pkg::DEPTH];
  logic [scer_pkg::ENTRY_W-1:0] rd_q;
  logic [scer_pkg::ENTRY_W-1:0] ent_q;
  logic [scer_pkg::PC_W-1:0]    pc_q [WORDS];

  logic                          out_valid_q;
  logic [scer_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic             wr_en;
  logic [PTR_W-1:0] wp_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic [CALC_W-1:0] age_ext, back, base, slot_full;
  logic [PTR_W-1:0] rd_addr;
  logic             entry_ok, older_ok;
  logic [SIG_W-1:0] older_sig, diff_sig;
  logic [scer_pkg::CHG_W-1:0] chg_sum;

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_sig_q <= in_tdata_i[scer_pkg::IN_SIG_LSB +: SIG_W];
      in_sec_q <= in_tdata_i[scer_pkg::IN_SEC_LSB +: SEC_W];
      in_ms_q  <= in_tdata_i[scer_pkg::IN_MS_LSB +: MS_W];
      in_age_q <= in_tdata_i[scer_pkg::IN_AGE_LSB +: scer_pkg::AGE_W];
    end
  end

  // Sample decision and pointer steps
  assign wr_en   = (in_sig_q != last_q) && (in_sec_q >= min_time_q);
  assign wp_inc  = (wp_q == PTR_W'(scer_pkg::DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
  assign cnt_inc = (cnt_q == CNT_W'(scer_pkg::DEPTH)) ? cnt_q : cnt_q + CNT_W'(1);

  // Config, last vector, pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_time_q <= scer_pkg::MIN_TIME_RESET;
      last_q     <= '0;
      wp_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) min_time_q <= cfg_wdata_i;
      if (cmd_i.sample_go && wr_en) begin
        last_q <= in_sig_q;
        wp_q   <= wp_inc;
        cnt_q  <= cnt_inc;
      end
    end
  end

  // Slot of an age: (wp - 1 - age) mod depth, or one older
  assign age_ext   = CALC_W'(in_age_q);
  assign back      = age_ext + (cmd_i.rd_older ? CALC_W'(2) : CALC_W'(1));
  assign base      = CALC_W'(wp_q) + CALC_W'(scer_pkg::DEPTH) - back;
  assign slot_full = (base >= CALC_W'(scer_pkg::DEPTH)) ? base - CALC_W'(scer_pkg::DEPTH)
                                                        : base;
  assign rd_addr   = slot_full[PTR_W-1:0];

  assign entry_ok = age_ext < CALC_W'(cnt_q);
  assign older_ok = (age_ext + CALC_W'(1)) < CALC_W'(cnt_q);

  // Ring memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_go && wr_en) begin
      ring_mem[wp_q] <= {in_ms_q, in_sec_q, in_sig_q};
    end
    if (cmd_i.rd_en) begin
      rd_q <= ring_mem[rd_addr];
    end
  end

  // Newest entry held while the older one is read
  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_load) ent_q <= rd_q;
  end

  // Per-word popcount of the difference
  assign older_sig = older_ok ? rd_q[SIG_W-1:0] : '0;
  assign diff_sig  = ent_q[SIG_W-1:0] ^ older_sig;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pc_load) begin
      for (int w = 0; w < WORDS; w++) begin
        pc_q[w] <= scer_pkg::popcount32(diff_sig[w*32 +: 32]);
      end
    end
  end

  // Sum of the word counts
  always_comb begin
    chg_sum = '0;
    for (int w = 0; w < WORDS; w++) begin
      chg_sum = chg_sum + scer_pkg::CHG_W'(pc_q[w]);
    end
  end

  // Result assembly
  always_comb begin
    out_data_d = '0;
    if (cmd_i.sample_go) begin
      out_data_d[scer_pkg::O_REC] = wr_en;
      out_data_d[scer_pkg::O_CNT_LSB +: scer_pkg::STORED_W] =
        scer_pkg::STORED_W'(wr_en ? cnt_inc : cnt_q);
    end else begin
      out_data_d[scer_pkg::O_CNT_LSB +: scer_pkg::STORED_W] = scer_pkg::STORED_W'(cnt_q);
      if (entry_ok) begin
        out_data_d[scer_pkg::O_VALID]               = 1'b1;
        out_data_d[scer_pkg::O_SIG_LSB +: SIG_W]    = ent_q[SIG_W-1:0];
        out_data_d[scer_pkg::O_SEC_LSB +: SEC_W]    = ent_q[SIG_W +: SEC_W];
        out_data_d[scer_pkg::O_MS_LSB +: MS_W]      = ent_q[SIG_W+SEC_W +: MS_W];
        out_data_d[scer_pkg::O_CHG_LSB +: scer_pkg::CHG_W] = chg_sum;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.sample_go || cmd_i.read_go) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_go || cmd_i.read_go) out_data_q <= out_data_d;
  end

  assign sts_o.out_free = !out_valid_q || out_tready_i;
  assign out_tvalid_o   = out_valid_q;
  assign out_tdata_o    = out_data_q;

endmodule

// File: sv/signal_change_event_recorder.sv
`timescale 1ns / 1ps
// Top level of the signal change event recorder.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample or read item, tuser: command
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: one result item per input item
// cfg       in         cfg_we_i                       cfg_wdata_i: min_valid_time
//
// A sample is a capture, then a compare and ring write; the steps of a read are
// set by the single read port of the ring: newest entry, older entry,
// per-word popcount, sum. One item is in work at a time.
// Reset clears the pointers, the stored count and the last recorded vector; the
// ring itself needs no clearing. A stalled result waits in the output register
// and the next item is still accepted; its result waits for that register.
module signal_change_event_recorder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // signals_0..3 [255:0], signals_4 [287:256], time_seconds [350:288],
  // time_millis [360:351], age_index [369:361], zero fill [375:370]
  input  logic [scer_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // command [0]
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // recorded [0], stored_count [10:1], entry_valid [11], out_signals_0..3 [267:12],
  // out_signals_4 [299:268], out_seconds [362:300], out_millis [372:363],
  // change_count [381:373], zero fill [383:382]
  output logic [scer_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we_i,
  input  logic [scer_pkg::SEC_W-1:0]           cfg_wdata_i
);

  scer_pkg::scer_cmd_t cmd;
  scer_pkg::scer_sts_t sts;

  scer_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .cmd_read_i    (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  scer_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tdata_i   (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata)
  );

  // One item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // Stored count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[scer_pkg::O_CNT_LSB +: scer_pkg::STORED_W]
                      <= scer_pkg::STORED_W'(scer_pkg::DEPTH))
    else $error("stored count beyond depth");

  // A result is either a sample or a read, never both
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[scer_pkg::O_REC] && m_axis_tdata[scer_pkg::O_VALID]))
    else $error("recorded and entry_valid both set");

  // Invalid read carries no change count
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[scer_pkg::O_VALID]
      |-> m_axis_tdata[scer_pkg::O_CHG_LSB +: scer_pkg::CHG_W] == '0)
    else $error("change count set without a valid entry");

endmodule

// File: dv/signal_change_event_recorder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the signal change event recorder: stream driver, predictor, checks.

// One result item, as the block should send it
typedef struct packed {
  logic [scer_pkg::CHG_W-1:0]    change_count;
  logic [scer_pkg::MS_W-1:0]     millis;
  logic [scer_pkg::SEC_W-1:0]    seconds;
  logic [scer_pkg::SIG_W-1:0]    signals;
  logic                          entry_valid;
  logic [scer_pkg::STORED_W-1:0] stored_count;
  logic                          recorded;
} recorder_result_t;

// Tracks the event ring and compares every result item against it
class event_log_scoreboard;
  logic [scer_pkg::SEC_W-1:0] min_time;
  logic [scer_pkg::SIG_W-1:0] last_sig;
  logic [scer_pkg::SIG_W-1:0] ring_sig [scer_pkg::DEPTH];
  logic [scer_pkg::SEC_W-1:0] ring_sec [scer_pkg::DEPTH];
  logic [scer_pkg::MS_W-1:0]  ring_ms  [scer_pkg::DEPTH];
  int unsigned                wr_ptr;
  int unsigned                stored;
  recorder_result_t           pending_results[$];
  int unsigned                errors;
  int unsigned                n_samples;
  int unsigned                n_recorded;
  int unsigned                n_reads;
  int unsigned                n_valid_reads;
  int unsigned                n_checked;
  bit                         ring_wrapped;

  function new();
    min_time     = scer_pkg::MIN_TIME_RESET;
    last_sig     = '0;
    wr_ptr       = 0;
    stored       = 0;
    errors       = 0;
    ring_wrapped = 1'b0;
  endfunction

  // Update the ring for one accepted item and queue the result it must produce
  function void predict_item(logic cmd, logic [scer_pkg::SIG_W-1:0] sig,
                             logic [scer_pkg::SEC_W-1:0] sec, logic [scer_pkg::MS_W-1:0] ms,
                             logic [scer_pkg::AGE_W-1:0] age);
    recorder_result_t r;
    int unsigned      age_i;
    int unsigned      slot;
    logic [scer_pkg::SIG_W-1:0] older;
    r     = '0;
    age_i = int'(age);
    if (cmd == scer_pkg::CMD_SAMPLE) begin
      n_samples++;
      // New entry only on a change, and only once the clock is set
      if (sec >= min_time && sig != last_sig) begin
        ring_sig[wr_ptr] = sig;
        ring_sec[wr_ptr] = sec;
        ring_ms[wr_ptr]  = ms;
        last_sig         = sig;
        wr_ptr           = (wr_ptr + 1) % scer_pkg::DEPTH;
        if (stored < scer_pkg::DEPTH) stored++;
        else ring_wrapped = 1'b1;
        r.recorded = 1'b1;
        n_recorded++;
      end
      r.stored_count = scer_pkg::STORED_W'(stored);
    end else begin
      n_reads++;
      r.stored_count = scer_pkg::STORED_W'(stored);
      if (age_i < stored) begin
        slot = (wr_ptr + scer_pkg::DEPTH - 1 - age_i) % scer_pkg::DEPTH;
        // oldest entry is compared with the zero vector
        if (age_i + 1 < stored)
          older = ring_sig[(wr_ptr + 2 * scer_pkg::DEPTH - 2 - age_i) % scer_pkg::DEPTH];
        else
          older = '0;
        r.entry_valid  = 1'b1;
        r.signals      = ring_sig[slot];
        r.seconds      = ring_sec[slot];
        r.millis       = ring_ms[slot];
        r.change_count = scer_pkg::CHG_W'($countones(ring_sig[slot] ^ older));
        n_valid_reads++;
      end
    end
    pending_results.push_back(r);
  endfunction

  function void diff(string name, logic [319:0] want, logic [319:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Compare one result item with the oldest expectation
  function void check_result(logic [scer_pkg::OUT_TDATA_W-1:0] d);
    recorder_result_t e;
    logic [319:0]     want_sig;
    logic [319:0]     got_sig;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: result item with nothing expected, expected none, actual %0h", $time, d);
      return;
    end
    e = pending_results.pop_front();
    n_checked++;
    want_sig = 320'(e.signals);
    got_sig  = 320'(d[scer_pkg::O_SIG_LSB +: scer_pkg::SIG_W]);
    diff("recorded", 320'(e.recorded), 320'(d[scer_pkg::O_REC]));
    diff("stored_count", 320'(e.stored_count), 320'(d[scer_pkg::O_CNT_LSB +: scer_pkg::STORED_W]));
    diff("entry_valid", 320'(e.entry_valid), 320'(d[scer_pkg::O_VALID]));
    for (int w = 0; w < 5; w++)
      diff($sformatf("out_signals_%0d", w), 320'(want_sig[64*w +: 64]), 320'(got_sig[64*w +: 64]));
    diff("out_seconds", 320'(e.seconds), 320'(d[scer_pkg::O_SEC_LSB +: scer_pkg::SEC_W]));
    diff("out_millis", 320'(e.millis), 320'(d[scer_pkg::O_MS_LSB +: scer_pkg::MS_W]));
    diff("change_count", 320'(e.change_count), 320'(d[scer_pkg::O_CHG_LSB +: scer_pkg::CHG_W]));
    diff("zero fill", 320'(0),
         320'(d[scer_pkg::OUT_TDATA_W-1 : scer_pkg::O_CHG_LSB + scer_pkg::CHG_W]));
  endfunction
endclass

module signal_change_event_recorder_tb;
  import scer_pkg::*;

  localparam int unsigned      STALL_LIMIT = 3000;
  localparam logic [SEC_W-1:0] SEC_MAX     = '1;

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i;
  logic [SEC_W-1:0]       cfg_wdata_i;

  event_log_scoreboard sb;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  bit                  calm;
  int unsigned         quiet_cycles = 0;
  int unsigned         n_cfg_writes;

  signal_change_event_recorder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, none during calm stretches
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SIG_W-1:0] rand_vec();
    logic [SIG_W-1:0] v;
    for (int k = 0; k < WORDS; k++) v[32*k +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [SEC_W-1:0] rand_secs();
    return SEC_W'({$urandom, $urandom});
  endfunction

  // Seconds mostly at or above the floor, some below it, some exactly on it
  function automatic logic [SEC_W-1:0] pick_seconds(logic [SEC_W-1:0] floor_s);
    logic [63:0] r;
    logic [63:0] span;
    int unsigned p;
    r = {$urandom, $urandom};
    p = $urandom_range(0, 99);
    if (p < 15 && floor_s != '0) return SEC_W'(r % 64'(floor_s));
    if (p < 25) return floor_s;
    span = 64'h8000_0000_0000_0000 - 64'(floor_s);
    return SEC_W'(64'(floor_s) + r % span);
  endfunction

  // Send one item, idling first at random
  task automatic drive_item(input logic cmd, input logic [SIG_W-1:0] sig,
                            input logic [SEC_W-1:0] sec, input logic [MS_W-1:0] ms,
                            input logic [AGE_W-1:0] age);
    logic [IN_TDATA_W-1:0] data;
    data = '0;
    data[IN_SIG_LSB +: SIG_W] = sig;
    data[IN_SEC_LSB +: SEC_W] = sec;
    data[IN_MS_LSB +: MS_W]   = ms;
    data[IN_AGE_LSB +: AGE_W] = age;
    while (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.predict_item(cmd, sig, sec, ms, age);
  endtask

  task automatic sample_item(input logic [SIG_W-1:0] sig, input logic [SEC_W-1:0] sec,
                             input logic [MS_W-1:0] ms);
    drive_item(CMD_SAMPLE, sig, sec, ms, AGE_W'($urandom));
  endtask

  // Fields other than the age are don't-care on a read; fill them randomly
  task automatic read_item(input logic [AGE_W-1:0] age);
    drive_item(CMD_READ, rand_vec(), rand_secs(), MS_W'($urandom_range(0, 999)), age);
  endtask

  // Stop sending and wait until every result item has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_min_time(input logic [SEC_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.min_time = v;
    n_cfg_writes++;
    @(posedge clk_i);
  endtask

  // Mixed samples and reads; samples repeat the last vector, flip one to eight of its bits, or are random
  task automatic random_phase(input int unsigned n_items);
    int unsigned      p;
    int unsigned      q;
    logic [SIG_W-1:0] v;
    logic [AGE_W-1:0] age;
    for (int unsigned i = 0; i < n_items; i++) begin
      calm = (i % 40) < 5;
      if (i == n_items / 2) drain_results();
      p = $urandom_range(0, 99);
      if (p < 35) begin
        q = $urandom_range(0, 9);
        if (sb.stored == 0 || q < 2) age = AGE_W'($urandom_range(0, 511));
        else if (q < 3) age = AGE_W'(sb.stored - 1);
        else age = AGE_W'($urandom_range(0, sb.stored - 1));
        read_item(age);
      end else begin
        if (p < 42) begin
          v = sb.last_sig;
        end else if (p < 65) begin
          v = sb.last_sig;
          q = $urandom_range(1, 8);
          for (int unsigned k = 0; k < q; k++) v[$urandom_range(0, SIG_W - 1)] ^= 1'b1;
        end else begin
          v = rand_vec();
        end
        sample_item(v, pick_seconds(sb.min_time), MS_W'($urandom_range(0, 999)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    sb             = new();
    n_cfg_writes   = 0;
    rst_ni         = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = CMD_SAMPLE;
    s_axis_tvalid  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    calm           = 1'b0;
    send_idle_pct  = 35;
    recv_stall_pct = 86;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, threshold at its reset value
    read_item(AGE_W'(0));                                  // empty ring
    sample_item('0, SEC_MAX, MS_W'(5));                    // equals reset vector
    sample_item('1, MIN_TIME_RESET - 1, MS_W'(7));         // clock not yet set
    sample_item('1, MIN_TIME_RESET, MS_W'(0));             // exactly on threshold
    sample_item('1, SEC_MAX, MS_W'(3));                    // unchanged
    sample_item({36{8'h55}}, SEC_MAX, MS_W'(999));
    sample_item({36{8'hAA}}, MIN_TIME_RESET + 1, MS_W'(512));
    read_item(AGE_W'(0));
    read_item(AGE_W'(1));
    read_item(AGE_W'(2));                                  // oldest, compared with zero
    read_item(AGE_W'(3));                                  // beyond stored
    read_item(AGE_W'(511));
    sample_item('0, '0, MS_W'(1));                         // zero seconds, ignored
    sample_item('0, SEC_MAX, MS_W'(1));
    read_item(AGE_W'(0));
    sample_item({1'b1, {(SIG_W - 1){1'b0}}}, MIN_TIME_RESET, MS_W'(2));
    read_item(AGE_W'(0));
    read_item(AGE_W'(4));

    // Random phases across threshold settings and idling patterns
    drain_results();
    write_min_time('0);
    random_phase(700);

    send_idle_pct  = 86;
    recv_stall_pct = 35;
    drain_results();
    write_min_time(SEC_MAX);
    random_phase(150);
    drain_results();
    write_min_time(rand_secs());
    random_phase(550);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_results();
    write_min_time(SEC_W'($urandom));
    random_phase(600);

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d samples (%0d recorded, ring wrapped: %0d), %0d reads (%0d hit)",
             sb.n_samples, sb.n_recorded, sb.ring_wrapped, sb.n_reads, sb.n_valid_reads);
    $display("%0d result items checked over %0d threshold settings, %0d errors",
             sb.n_checked, n_cfg_writes + 1, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/scer_pkg.sv
sv/scer_ctrl.sv
sv/scer_datapath.sv
sv/signal_change_event_recorder.sv
dv/signal_change_event_recorder_tb.sv
